>>> hw/rtl/json_string_unescape_utf8_core_defines.svh
// Assertion macros for the RTL of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define JSUC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define JSUC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define JSUC_ASSERT(lbl, clk, rstn, prop, msg)
`define JSUC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

>>> hw/rtl/jsu_pkg.sv
package jsu_pkg;

    localparam int BEATS_MAX = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       string_done;
        logic [2:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] hex_acc;
        logic [2:0]  hex_cnt;
        logic        hex_frozen;
        logic [15:0] high_sur;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]                    count;
        out_item_t [BEATS_MAX-1:0]     beats;
    } step_res_t;

    localparam logic [2:0] MODE_WAIT = 3'd0;
    localparam logic [2:0] MODE_BODY = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX1 = 3'd3;
    localparam logic [2:0] MODE_LBS  = 3'd4;
    localparam logic [2:0] MODE_LU   = 3'd5;
    localparam logic [2:0] MODE_HEX2 = 3'd6;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC    = 3'd2;
    localparam logic [2:0] ERR_TRUNC_ESC  = 3'd3;
    localparam logic [2:0] ERR_NO_LOW_SUR = 3'd4;
    localparam logic [2:0] ERR_UNTERM     = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [31:0] SUR_LO_BASE = 32'h0000DC00;
    localparam logic [31:0] SUR_HI_BASE = 32'h0000D800;
    localparam logic [31:0] PLANE1_BASE = 32'h00010000;

    localparam parse_state_t STATE_RESET = '{
        mode: MODE_WAIT, hex_acc: 16'd0, hex_cnt: 3'd0, hex_frozen: 1'b0, high_sur: 16'd0
    };

    localparam out_item_t BEAT_IDLE = '0;

    function automatic out_item_t data_beat(input logic [7:0] b);
        out_item_t r;
        r = BEAT_IDLE;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic out_item_t err_beat(input logic [2:0] code);
        out_item_t r;
        r = BEAT_IDLE;
        r.error_code = code;
        return r;
    endfunction

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    function automatic step_res_t utf8_burst(input logic [31:0] cp);
        step_res_t r;
        r = '0;
        if (cp < 32'h80) begin
            r.count    = 3'd1;
            r.beats[0] = data_beat(cp[7:0]);
        end else if (cp < 32'h800) begin
            r.count    = 3'd2;
            r.beats[0] = data_beat({3'b110, cp[10:6]});
            r.beats[1] = data_beat({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
            r.count    = 3'd3;
            r.beats[0] = data_beat({4'b1110, cp[15:12]});
            r.beats[1] = data_beat({2'b10, cp[11:6]});
            r.beats[2] = data_beat({2'b10, cp[5:0]});
        end else begin
            // Wrapped surrogate sums can exceed 21 bits; the lead byte is
            // 8'hF0 ORed with cp[25:18].
            r.count    = 3'd4;
            r.beats[0] = data_beat(8'hF0 | cp[25:18]);
            r.beats[1] = data_beat({2'b10, cp[17:12]});
            r.beats[2] = data_beat({2'b10, cp[11:6]});
            r.beats[3] = data_beat({2'b10, cp[5:0]});
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/jsu_step.sv
module jsu_step (
    input  jsu_pkg::parse_state_t cur_state,
    input  jsu_pkg::in_item_t     item,
    output jsu_pkg::parse_state_t nxt_state,
    output jsu_pkg::step_res_t    res
);
    import jsu_pkg::*;

    logic [4:0]  hx;
    logic [15:0] acc_take;
    logic        frozen_take;
    logic [2:0]  cnt_take;
    logic        group_done;
    logic [31:0] pair_cp;

    always_comb begin
        hx          = hex_digit(item.in_byte);
        acc_take    = (!cur_state.hex_frozen && hx[4]) ? {cur_state.hex_acc[11:0], hx[3:0]}
                                                       : cur_state.hex_acc;
        frozen_take = cur_state.hex_frozen | ~hx[4];
        cnt_take    = cur_state.hex_cnt + 3'd1;
        group_done  = cnt_take[2];
        pair_cp     = PLANE1_BASE + (({16'd0, cur_state.high_sur} - SUR_HI_BASE) << 10)
                      + ({16'd0, acc_take} - SUR_LO_BASE);

        nxt_state = cur_state;
        res       = '0;

        if (item.input_end) begin
            nxt_state = STATE_RESET;
            res.count = 3'd1;
            case (cur_state.mode)
                MODE_BODY:                       res.beats[0] = err_beat(ERR_UNTERM);
                MODE_ESC, MODE_HEX1, MODE_HEX2:  res.beats[0] = err_beat(ERR_TRUNC_ESC);
                MODE_LBS, MODE_LU:               res.beats[0] = err_beat(ERR_NO_LOW_SUR);
                default:                         res.beats[0] = err_beat(ERR_NO_QUOTE);
            endcase
        end else begin
            case (cur_state.mode)
                MODE_BODY: begin
                    if (item.in_byte == CH_QUOTE) begin
                        nxt_state = STATE_RESET;
                        res.count = 3'd1;
                        res.beats[0] = BEAT_IDLE;
                        res.beats[0].string_done = 1'b1;
                    end else if (item.in_byte == CH_BSLASH) begin
                        nxt_state.mode = MODE_ESC;
                    end else begin
                        res.count    = 3'd1;
                        res.beats[0] = data_beat(item.in_byte);
                    end
                end
                MODE_ESC: begin
                    nxt_state.mode = MODE_BODY;
                    res.count      = 3'd1;
                    case (item.in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.beats[0] = data_beat(item.in_byte);
                        CH_B: res.beats[0] = data_beat(8'h08);
                        CH_F: res.beats[0] = data_beat(8'h0C);
                        CH_N: res.beats[0] = data_beat(8'h0A);
                        CH_R: res.beats[0] = data_beat(8'h0D);
                        CH_T: res.beats[0] = data_beat(8'h09);
                        CH_U: begin
                            nxt_state.mode       = MODE_HEX1;
                            nxt_state.hex_acc    = 16'd0;
                            nxt_state.hex_cnt    = 3'd0;
                            nxt_state.hex_frozen = 1'b0;
                            res.count            = 3'd0;
                        end
                        default: begin
                            nxt_state    = STATE_RESET;
                            res.beats[0] = err_beat(ERR_BAD_ESC);
                        end
                    endcase
                end
                MODE_HEX1: begin
                    nxt_state.hex_acc    = acc_take;
                    nxt_state.hex_cnt    = cnt_take;
                    nxt_state.hex_frozen = frozen_take;
                    if (group_done) begin
                        nxt_state.hex_acc    = 16'd0;
                        nxt_state.hex_cnt    = 3'd0;
                        nxt_state.hex_frozen = 1'b0;
                        if (acc_take >= SUR_HI_MIN && acc_take <= SUR_HI_MAX) begin
                            nxt_state.high_sur = acc_take;
                            nxt_state.mode     = MODE_LBS;
                        end else begin
                            nxt_state.mode = MODE_BODY;
                            res            = utf8_burst({16'd0, acc_take});
                        end
                    end
                end
                MODE_LBS: begin
                    if (item.in_byte == CH_BSLASH) begin
                        nxt_state.mode = MODE_LU;
                    end else begin
                        nxt_state    = STATE_RESET;
                        res.count    = 3'd1;
                        res.beats[0] = err_beat(ERR_NO_LOW_SUR);
                    end
                end
                MODE_LU: begin
                    if (item.in_byte == CH_U) begin
                        nxt_state.mode = MODE_HEX2;
                    end else begin
                        nxt_state    = STATE_RESET;
                        res.count    = 3'd1;
                        res.beats[0] = err_beat(ERR_NO_LOW_SUR);
                    end
                end
                MODE_HEX2: begin
                    nxt_state.hex_acc    = acc_take;
                    nxt_state.hex_cnt    = cnt_take;
                    nxt_state.hex_frozen = frozen_take;
                    if (group_done) begin
                        nxt_state = STATE_RESET;
                        nxt_state.mode = MODE_BODY;
                        res = utf8_burst(pair_cp);
                    end
                end
                default: begin
                    // Waiting for the opening quote; the unused mode code lands here too.
                    nxt_state = STATE_RESET;
                    if (item.in_byte == CH_QUOTE) begin
                        nxt_state.mode = MODE_BODY;
                    end else begin
                        res.count    = 3'd1;
                        res.beats[0] = err_beat(ERR_NO_QUOTE);
                    end
                end
            endcase
        end

        for (int k = 0; k < BEATS_MAX; k++) begin
            res.beats[k].last_of_run = (3'(k + 1) == res.count);
        end
    end

endmodule

>>> hw/rtl/jsu_burst.sv
`include "json_string_unescape_utf8_core_defines.svh"

module jsu_burst (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  jsu_pkg::step_res_t  res,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output jsu_pkg::out_item_t  m_item
);
    import jsu_pkg::*;

    out_item_t [BEATS_MAX-1:0] beats_reg;
    out_item_t [BEATS_MAX-1:0] beats_next;
    logic [2:0]                rem_reg;
    logic [2:0]                rem_next;

    assign m_valid = (rem_reg != 3'd0);
    assign m_item  = beats_reg[0];
    assign free    = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_ready);

    always_comb begin
        beats_next = beats_reg;
        rem_next   = rem_reg;
        if (load) begin
            beats_next = res.beats;
            rem_next   = res.count;
        end else if (m_valid && m_ready) begin
            beats_next = {BEAT_IDLE, beats_reg[BEATS_MAX-1:1]};
            rem_next   = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        beats_reg <= beats_next;
        if (!aresetn) begin
            rem_reg <= 3'd0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    `JSUC_ASSERT(a_rem_range, aclk, aresetn, rem_reg <= 3'd4, "burst count out of range")
    `JSUC_ASSERT(a_load_free, aclk, aresetn, load |-> free, "burst loaded while beats remain")
    `JSUC_ASSERT(a_last_flag, aclk, aresetn, (m_valid && rem_reg == 3'd1) |-> m_item.last_of_run, "final beat lacks last_of_run")
    `JSUC_ASSERT_NEVER(a_early_last, aclk, aresetn, rem_reg > 3'd1 && m_item.last_of_run, "last_of_run before end of burst")
    `JSUC_ASSERT(a_shift, aclk, aresetn, (m_valid && m_ready && !load && rem_reg > 3'd1) |=> m_item == $past(beats_reg[1]), "burst beat order broken")

endmodule

>>> hw/rtl/json_string_unescape_utf8_core.sv
// Channel | Ports                       | Beat
// input   | s_valid, s_ready, s_item    | one source byte or end marker
// result  | m_valid, m_ready, m_item    | one decoded byte, done or error
//
// Items are taken one per cycle while m_ready is high and each gives at most one result beat.
// An item that gives n beats (a UTF-8 sequence of up to four bytes) holds the
// input while the four-entry burst register drains, one beat a cycle while m_ready is high.
// An accepted item is held in the input register, then loaded into the burst register that offers its first beat.
// aresetn is synchronous and returns the parser to waiting for an opening quote.
// A low m_ready holds the burst; once the input register is also full, s_ready drops.
module json_string_unescape_utf8_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jsu_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output jsu_pkg::out_item_t m_item
);
    import jsu_pkg::*;

    in_item_t     in_item_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    parse_state_t state_reg;
    parse_state_t state_next;
    step_res_t    step_res;
    logic         burst_free;
    logic         advance;

    assign advance       = in_valid_reg && burst_free;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    jsu_step u_step (
        .cur_state (state_reg),
        .item      (in_item_reg),
        .nxt_state (state_next),
        .res       (step_res)
    );

    jsu_burst u_burst (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res     (step_res),
        .free    (burst_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

endmodule
